### sv/gpvu_pkg.sv
// ----------------------------------------------------------------------------
// gpvu_pkg
// shared widths, constants and side-band types of the pair velocity pipeline
// ----------------------------------------------------------------------------
package gpvu_pkg;

  localparam int unsigned POS_W      = 32;
  localparam int unsigned MASS_W     = 32;
  localparam int unsigned STEP_W     = 32;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned DIFF_W     = 33;
  localparam int unsigned SQ_W       = 66;
  localparam int unsigned ROOT_W     = 33;
  localparam int unsigned SQRT_REM_W = 34;
  localparam int unsigned DIST_W     = 35;
  localparam int unsigned RATIO_W    = 30;
  localparam int unsigned GAIN_W     = 59;
  localparam int unsigned UNIT_W     = 31;
  localparam int unsigned NUM_W      = 64;
  localparam int unsigned GM_W       = 62;
  localparam int unsigned PROD_W     = 90;
  localparam int unsigned MAG_W      = 31;
  localparam int unsigned PROD_SHIFT = 46;
  localparam int unsigned UNIT_SHIFT = 30;
  localparam int unsigned GAIN_LO_W  = 32;
  localparam int unsigned IN_DATA_W  = 192;
  localparam int unsigned OUT_DATA_W = 128;
  localparam int unsigned LANES      = 4;

  localparam logic [STEP_W-1:0] TIME_STEP_RESET = 32'd1092;
  localparam logic [OUT_W-1:0]  SAT_POS         = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0]  SAT_NEG         = 32'h8000_0000;

  // divider lanes
  localparam int unsigned LANE_GAIN_A = 0;
  localparam int unsigned LANE_GAIN_B = 1;
  localparam int unsigned LANE_UNIT_X = 2;
  localparam int unsigned LANE_UNIT_Y = 3;

  typedef struct packed {
    logic [DIFF_W-1:0] abs_x;
    logic [DIFF_W-1:0] abs_y;
    logic              neg_x;
    logic              neg_y;
    logic [MASS_W-1:0] mass_a;
    logic [MASS_W-1:0] mass_b;
  } pair_side_t;

  typedef struct packed {
    pair_side_t        pair;
    logic [DIST_W-1:0] sep_len;
  } dist_side_t;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
  } sign_t;

endpackage

### sv/gpvu_sqrt.sv
// ----------------------------------------------------------------------------
// gpvu_sqrt
// pipelined integer square root, one root bit per register stage
// ----------------------------------------------------------------------------
module gpvu_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [gpvu_pkg::SQ_W-1:0]   radicand,
  input  gpvu_pkg::pair_side_t        in_side,
  output logic                        out_valid,
  output logic [gpvu_pkg::ROOT_W-1:0] root,
  output gpvu_pkg::pair_side_t        out_side
);
  import gpvu_pkg::*;

  localparam int unsigned STEPS = ROOT_W;

  logic                  vld  [STEPS+1];
  logic [SQRT_REM_W-1:0] rem  [STEPS+1];
  logic [ROOT_W-1:0]     acc  [STEPS+1];
  logic [SQ_W-1:0]       rad  [STEPS+1];
  pair_side_t            side [STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= '0;
      acc[0]  <= '0;
      rad[0]  <= radicand;
      side[0] <= in_side;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [SQRT_REM_W+1:0] cur;
    logic [SQRT_REM_W+1:0] trial;
    logic                  fits;

    always_comb begin
      cur   = {rem[k], rad[k][SQ_W-1 -: 2]};
      trial = (SQRT_REM_W+2)'({acc[k], 2'b01});
      fits  = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= fits ? SQRT_REM_W'(cur - trial) : SQRT_REM_W'(cur);
        acc[k+1]  <= {acc[k][ROOT_W-2:0], fits};
        rad[k+1]  <= rad[k] << 2;
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[STEPS];
  assign root      = acc[STEPS];
  assign out_side  = side[STEPS];

endmodule

### sv/gpvu_div.sv
// ----------------------------------------------------------------------------
// gpvu_div
// pipelined restoring divider, one quotient bit per stage, lanes share divisor
// ----------------------------------------------------------------------------
module gpvu_div #(
  parameter int unsigned NW    = 64,
  parameter int unsigned DW    = 35,
  parameter int unsigned QW    = 30,
  parameter int unsigned NLANE = 1,
  parameter int unsigned SW    = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [NLANE-1:0][NW-1:0]  dividend,
  input  logic [DW-1:0]             divisor,
  input  logic [SW-1:0]             in_side,
  output logic                      out_valid,
  output logic [NLANE-1:0][QW-1:0]  quotient,
  output logic [SW-1:0]             out_side
);

  logic                     vld  [QW+1];
  logic [NLANE-1:0][DW-1:0] rem  [QW+1];
  logic [NLANE-1:0][QW-1:0] quo  [QW+1];
  logic [DW-1:0]            dvs  [QW+1];
  logic [SW-1:0]            side [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  // quotient is known to fit QW bits, so the top bits start as remainder
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NLANE; l++) begin
        rem[0][l] <= DW'(dividend[l] >> QW);
        quo[0][l] <= dividend[l][QW-1:0];
      end
      dvs[0]  <= divisor;
      side[0] <= in_side;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [NLANE-1:0][DW-1:0] rem_next;
    logic [NLANE-1:0]         qbit;

    always_comb begin
      logic [DW:0] cur;
      for (int l = 0; l < NLANE; l++) begin
        cur         = {rem[k][l], quo[k][l][QW-1]};
        qbit[l]     = (cur >= {1'b0, dvs[k]});
        rem_next[l] = qbit[l] ? DW'(cur - {1'b0, dvs[k]}) : DW'(cur);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= rem_next;
        for (int l = 0; l < NLANE; l++) begin
          quo[k+1][l] <= {quo[k][l][QW-2:0], qbit[l]};
        end
        dvs[k+1]  <= dvs[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[QW];
  assign quotient  = quo[QW];
  assign out_side  = side[QW];

endmodule

### sv/gpvu_scale.sv
// ----------------------------------------------------------------------------
// gpvu_scale
// gain times unit vector, shifted to Q16.16, signed and saturated or zeroed (3 stages)
// ----------------------------------------------------------------------------
module gpvu_scale (
  input  logic                        clk,
  input  logic                        en,
  input  logic                        zero,
  input  logic                        neg,
  input  logic [gpvu_pkg::GAIN_W-1:0] gain,
  input  logic [gpvu_pkg::UNIT_W-1:0] unit,
  output logic [gpvu_pkg::OUT_W-1:0]  vel
);
  import gpvu_pkg::*;

  localparam int unsigned HI_W = GAIN_W - GAIN_LO_W;

  logic [GAIN_LO_W+UNIT_W-1:0] p_lo;
  logic [HI_W+UNIT_W-1:0]      p_hi;
  logic                        neg1, zero1, neg2, zero2;
  logic [PROD_W-1:0]           prod;
  logic                        over;
  logic [MAG_W-1:0]            mag;
  logic [OUT_W-1:0]            vel_next;

  always_ff @(posedge clk) begin
    if (en) begin
      p_lo  <= (GAIN_LO_W+UNIT_W)'(gain[GAIN_LO_W-1:0]) * (GAIN_LO_W+UNIT_W)'(unit);
      p_hi  <= (HI_W+UNIT_W)'(gain[GAIN_W-1:GAIN_LO_W]) * (HI_W+UNIT_W)'(unit);
      neg1  <= neg;
      zero1 <= zero;
      prod  <= (PROD_W'(p_hi) << GAIN_LO_W) + PROD_W'(p_lo);
      neg2  <= neg1;
      zero2 <= zero1;
      vel   <= vel_next;
    end
  end

  always_comb begin
    over = |prod[PROD_W-1:PROD_SHIFT+MAG_W];
    mag  = prod[PROD_SHIFT+MAG_W-1:PROD_SHIFT];
    if (zero2) begin
      vel_next = '0;
    end else if (neg2) begin
      vel_next = over ? SAT_NEG : OUT_W'(0) - {1'b0, mag};
    end else begin
      vel_next = over ? SAT_POS : {1'b0, mag};
    end
  end

endmodule

### sv/gravity_pair_velocity_update.sv
// ----------------------------------------------------------------------------
// gravity_pair_velocity_update
// pairwise 2-D gravity velocity change, Q16.16 fixed point
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one particle pair per request, m_axis one result request
//   with the velocity changes of both particles, pulled toward each other.
//   cfg_wr_en / cfg_wr_data write the time step; write it only while idle.
// pipeline depth and throughput
//   the pipeline has 132 register stages; one pair enters every cycle
//   unless the output stalls. the depth comes from the square root (34
//   stages), the dt/dist divider (31 stages) and the four-lane gain and
//   unit divider (60 stages); each has an input register followed by one
//   root or quotient bit per stage.
// reset
//   rst clears all valid bits and loads the time step with 1092.
// stall
//   the whole pipeline holds while m_axis_tvalid is high and m_axis_tready
//   is low; s_axis_tready drops for those cycles, nothing is lost or repeated.
// ----------------------------------------------------------------------------
module gravity_pair_velocity_update (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [gpvu_pkg::STEP_W-1:0]     cfg_wr_data,  // time_step
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // pos_x_a, pos_y_a, mass_a, pos_x_b, pos_y_b, mass_b
  input  logic [gpvu_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // vel_dx_a, vel_dy_a, vel_dx_b, vel_dy_b
  output logic [gpvu_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import gpvu_pkg::*;

  logic              en;
  logic [STEP_W-1:0] time_step;

  // input fields
  logic signed [POS_W-1:0] pos_x_a, pos_y_a, pos_x_b, pos_y_b;
  logic [MASS_W-1:0]       mass_a, mass_b;
  logic signed [DIFF_W-1:0] ex, ey;

  // stage a: differences
  logic       a_vld;
  pair_side_t a_side;
  // stage b: squares
  logic       b_vld;
  pair_side_t b_side;
  logic [SQ_W-1:0] sq_x, sq_y;
  // square root
  logic              rt_vld;
  logic [ROOT_W-1:0] rt_root;
  pair_side_t        rt_side;
  // stage c: clamped distance
  logic       c_vld;
  dist_side_t c_side;
  // dt / dist
  logic                        r_vld;
  logic [0:0][RATIO_W-1:0]     r_quo;
  logic [$bits(dist_side_t)-1:0] r_side_bits;
  dist_side_t                  r_side;
  // stage d: numerators
  logic                      d_vld;
  logic [LANES-1:0][NUM_W-1:0] d_num;
  logic [DIST_W-1:0]         d_dist;
  sign_t                     d_sign;
  // gains and unit vector
  logic                         g_vld;
  logic [LANES-1:0][GAIN_W-1:0] g_quo;
  logic [$bits(sign_t)-1:0]     g_side_bits;
  sign_t                        g_sign;
  // scaling
  logic [2:0]       sc_vld;
  logic             step_zero;
  logic [OUT_W-1:0] vel_dx_a, vel_dy_a, vel_dx_b, vel_dy_b;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign step_zero     = (time_step == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= TIME_STEP_RESET;
    end else if (cfg_wr_en) begin
      time_step <= cfg_wr_data;
    end
  end

  assign pos_x_a = s_axis_tdata[31:0];
  assign pos_y_a = s_axis_tdata[63:32];
  assign mass_a  = s_axis_tdata[95:64];
  assign pos_x_b = s_axis_tdata[127:96];
  assign pos_y_b = s_axis_tdata[159:128];
  assign mass_b  = s_axis_tdata[191:160];

  assign ex = DIFF_W'(pos_x_b) - DIFF_W'(pos_x_a);
  assign ey = DIFF_W'(pos_y_b) - DIFF_W'(pos_y_a);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld  <= 1'b0;
      b_vld  <= 1'b0;
      c_vld  <= 1'b0;
      d_vld  <= 1'b0;
      sc_vld <= '0;
    end else if (en) begin
      a_vld  <= s_axis_tvalid;
      b_vld  <= a_vld;
      c_vld  <= rt_vld;
      d_vld  <= r_vld;
      sc_vld <= {sc_vld[1:0], g_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side.neg_x  <= ex[DIFF_W-1];
      a_side.neg_y  <= ey[DIFF_W-1];
      a_side.abs_x  <= ex[DIFF_W-1] ? DIFF_W'(-ex) : DIFF_W'(ex);
      a_side.abs_y  <= ey[DIFF_W-1] ? DIFF_W'(-ey) : DIFF_W'(ey);
      a_side.mass_a <= mass_a;
      a_side.mass_b <= mass_b;

      sq_x   <= SQ_W'(a_side.abs_x) * SQ_W'(a_side.abs_x);
      sq_y   <= SQ_W'(a_side.abs_y) * SQ_W'(a_side.abs_y);
      b_side <= a_side;

      c_side.pair    <= rt_side;
      c_side.sep_len <= (DIST_W'(rt_root) > {time_step, 3'b000}) ?
                        DIST_W'(rt_root) : {time_step, 3'b000};

      d_num[LANE_GAIN_A] <= NUM_W'(GM_W'(r_side.pair.mass_b) * GM_W'(r_quo[0]));
      d_num[LANE_GAIN_B] <= NUM_W'(GM_W'(r_side.pair.mass_a) * GM_W'(r_quo[0]));
      d_num[LANE_UNIT_X] <= NUM_W'({r_side.pair.abs_x, UNIT_SHIFT'(0)});
      d_num[LANE_UNIT_Y] <= NUM_W'({r_side.pair.abs_y, UNIT_SHIFT'(0)});
      d_dist             <= r_side.sep_len;
      d_sign.neg_x       <= r_side.pair.neg_x;
      d_sign.neg_y       <= r_side.pair.neg_y;
    end
  end

  gpvu_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b_vld),
    .radicand  (sq_x + sq_y),
    .in_side   (b_side),
    .out_valid (rt_vld),
    .root      (rt_root),
    .out_side  (rt_side)
  );

  gpvu_div #(
    .NW    (NUM_W),
    .DW    (DIST_W),
    .QW    (RATIO_W),
    .NLANE (1),
    .SW    ($bits(dist_side_t))
  ) u_ratio_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_vld),
    .dividend  ({time_step, 32'h0}),
    .divisor   (c_side.sep_len),
    .in_side   (c_side),
    .out_valid (r_vld),
    .quotient  (r_quo),
    .out_side  (r_side_bits)
  );

  assign r_side = r_side_bits;

  gpvu_div #(
    .NW    (NUM_W),
    .DW    (DIST_W),
    .QW    (GAIN_W),
    .NLANE (LANES),
    .SW    ($bits(sign_t))
  ) u_gain_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_vld),
    .dividend  (d_num),
    .divisor   (d_dist),
    .in_side   (d_sign),
    .out_valid (g_vld),
    .quotient  (g_quo),
    .out_side  (g_side_bits)
  );

  assign g_sign = g_side_bits;

  gpvu_scale u_scale_xa (
    .clk  (clk),
    .en   (en),
    .zero (step_zero),
    .neg  (g_sign.neg_x),
    .gain (g_quo[LANE_GAIN_A]),
    .unit (g_quo[LANE_UNIT_X][UNIT_W-1:0]),
    .vel  (vel_dx_a)
  );

  gpvu_scale u_scale_ya (
    .clk  (clk),
    .en   (en),
    .zero (step_zero),
    .neg  (g_sign.neg_y),
    .gain (g_quo[LANE_GAIN_A]),
    .unit (g_quo[LANE_UNIT_Y][UNIT_W-1:0]),
    .vel  (vel_dy_a)
  );

  gpvu_scale u_scale_xb (
    .clk  (clk),
    .en   (en),
    .zero (step_zero),
    .neg  (!g_sign.neg_x),
    .gain (g_quo[LANE_GAIN_B]),
    .unit (g_quo[LANE_UNIT_X][UNIT_W-1:0]),
    .vel  (vel_dx_b)
  );

  gpvu_scale u_scale_yb (
    .clk  (clk),
    .en   (en),
    .zero (step_zero),
    .neg  (!g_sign.neg_y),
    .gain (g_quo[LANE_GAIN_B]),
    .unit (g_quo[LANE_UNIT_Y][UNIT_W-1:0]),
    .vel  (vel_dy_b)
  );

  assign m_axis_tvalid = sc_vld[2];
  assign m_axis_tdata  = {vel_dy_b, vel_dx_b, vel_dy_a, vel_dx_a};

endmodule
